/* src/flic_pkg.sv */
// ----------------------------------------------------------------------------
// flic_pkg: shared types and constants of the label index cache
// Row layout, way geometry and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package flic_pkg;

  // Cache geometry: four ways, each way holds a tag and a value
  localparam int unsigned NumWays  = 4;
  localparam int unsigned TagW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned WayW     = TagW + ValW;
  localparam int unsigned RowW     = NumWays * WayW;

  // Mode codes carried on the input tuser
  localparam logic ModeLookup = 1'b0;
  localparam logic ModeFill   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch a new input transaction
    logic mod_step;  // advance the set index reduction by one step
    logic rd_en;     // read the set row
    logic cmp;       // compare tags, form the result, update the row on a fill miss
    logic clr_wr;    // write one reset row during the clearing pass
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic label_neg; // incoming label is negative
    logic mod_done;  // the current reduction step is the last one
    logic clr_last;  // clearing pass is at the last row
  } status_t;

endpackage

/* src/flic_ram.sv */
// ----------------------------------------------------------------------------
// flic_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module flic_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/flic_ctrl.sv */
// ----------------------------------------------------------------------------
// flic_ctrl: sequencer of the label index cache
// Runs the clearing pass after reset, then steps each transaction through
// set reduction, row read, compare and result hand-off; a negative label goes straight to the hand-off.
// ----------------------------------------------------------------------------
module flic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  flic_pkg::status_t status_i,
  output flic_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StMod   = 6'b000100,
    StRead  = 6'b001000,
    StCmp   = 6'b010000,
    StResp  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = (state_q == StIdle) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.label_neg ? StResp : StMod;
        end
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_done) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StCmp;
      end
      StCmp: begin
        cmd_o.cmp = 1'b1;
        state_d   = StResp;
      end
      StResp: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  // Hold the result valid until the downstream side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // A negative label skips the cache and goes straight to the response
  a_neg_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.label_neg) |=> (state_q == StResp))
    else $error("negative label did not bypass the cache");

  // Compare only ever follows a row read
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> ($past(state_q) == StRead))
    else $error("compare without a preceding row read");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  // No input transaction is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o)
    else $error("input accepted during clearing pass");
`endif

endmodule

/* src/flic_dp.sv */
// ----------------------------------------------------------------------------
// flic_dp: datapath of the label index cache
// Holds the transaction, reduces the label to a set index, compares the four
// tags of the row, forms the shifted row on a fill miss and keeps the result.
// ----------------------------------------------------------------------------
module flic_dp #(
  parameter int unsigned NUM_SETS = 256,
  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_mode_i,
  input  logic [31:0]                 in_label_i,
  input  logic [31:0]                 in_fill_i,
  input  flic_pkg::cmd_t              cmd_i,
  output flic_pkg::status_t           status_o,
  output logic                        ram_wr_en_o,
  output logic [SetW-1:0]             ram_waddr_o,
  output logic [flic_pkg::RowW-1:0]   ram_wdata_o,
  output logic                        ram_rd_en_o,
  output logic [SetW-1:0]             ram_raddr_o,
  input  logic [flic_pkg::RowW-1:0]   ram_rdata_i,
  output logic                        out_hit_o,
  output logic [31:0]                 out_value_o
);

  localparam bit IsPow2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

  logic            mode_q;
  logic [31:0]     label_q;
  logic [31:0]     fill_q;
  logic            res_hit_q, res_hit_d;
  logic [31:0]     res_val_q, res_val_d;
  logic            out_hit_q;
  logic [31:0]     out_val_q;
  logic [SetW-1:0] set_idx;
  logic [SetW-1:0] clr_cnt_q;
  logic            mod_done;
  logic            any_match;
  logic [31:0]     match_val;

  // Latch the transaction fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= in_mode_i;
      label_q <= in_label_i;
      fill_q  <= in_fill_i;
    end
  end

  // Reduce the label to its set index
  if (IsPow2) begin : g_set_mask
    logic [SetW-1:0] set_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        set_q <= in_label_i[SetW-1:0] & SetW'(NUM_SETS - 1);
      end
    end

    assign set_idx  = set_q;
    assign mod_done = 1'b1;
  end else begin : g_set_recip
    // Reciprocal multiply over two steps: the quotient comes from the high
    // product bits, the remainder only needs the low SetW bits of label - q*N
    localparam int unsigned    ShiftS = 31 + SetW;
    localparam longint unsigned RecipM =
      ((64'd1 << ShiftS) / 64'(NUM_SETS)) + 64'd1;
    localparam logic [31:0]    RecipW = 32'(RecipM);

    logic [63:0]     prod_q;
    logic [SetW-1:0] rem_q;
    logic            step_q;
    logic [SetW-1:0] quot_low;
    logic [SetW-1:0] qn_low;

    assign quot_low = SetW'(prod_q >> ShiftS);
    assign qn_low   = SetW'(quot_low * SetW'(NUM_SETS));

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        step_q <= 1'b0;
      end else if (cmd_i.mod_step) begin
        if (!step_q) begin
          prod_q <= 64'(label_q[30:0]) * 64'(RecipW);
          step_q <= 1'b1;
        end else begin
          rem_q <= label_q[SetW-1:0] - qn_low;
        end
      end
    end

    assign set_idx  = rem_q;
    assign mod_done = step_q;
  end

  // Compare the four tags; the lowest matching way wins
  always_comb begin
    any_match = 1'b0;
    match_val = '0;
    for (int w = flic_pkg::NumWays - 1; w >= 0; w--) begin
      if (ram_rdata_i[w*flic_pkg::WayW +: flic_pkg::TagW] == label_q) begin
        any_match = 1'b1;
        match_val = ram_rdata_i[w*flic_pkg::WayW + flic_pkg::TagW +: flic_pkg::ValW];
      end
    end
  end

  // Form the result
  always_comb begin
    res_hit_d = res_hit_q;
    res_val_d = res_val_q;
    if (cmd_i.accept) begin
      res_hit_d = 1'b1;
      res_val_d = in_label_i;
    end else if (cmd_i.cmp) begin
      if (any_match) begin
        res_hit_d = 1'b1;
        res_val_d = match_val;
      end else if (mode_q == flic_pkg::ModeFill) begin
        res_hit_d = 1'b1;
        res_val_d = fill_q;
      end else begin
        res_hit_d = 1'b0;
        res_val_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q <= res_hit_d;
    res_val_q <= res_val_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q <= res_hit_q;
      out_val_q <= res_val_q;
    end
  end

  // Advance the clearing pass row by row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + SetW'(1);
    end
  end

  // Row write: reset row while clearing, shifted row on a fill miss
  assign ram_wr_en_o = cmd_i.clr_wr ||
                       (cmd_i.cmp && !any_match && (mode_q == flic_pkg::ModeFill));
  assign ram_waddr_o = cmd_i.clr_wr ? clr_cnt_q : set_idx;
  assign ram_wdata_o = cmd_i.clr_wr ? {flic_pkg::RowW{1'b1}} :
                       {ram_rdata_i[(flic_pkg::NumWays-1)*flic_pkg::WayW-1:0],
                        fill_q, label_q};
  assign ram_rd_en_o = cmd_i.rd_en;
  assign ram_raddr_o = set_idx;

  assign status_o.label_neg = in_label_i[31];
  assign status_o.mod_done  = mod_done;
  assign status_o.clr_last  = (clr_cnt_q == SetW'(NUM_SETS - 1));

  assign out_hit_o   = out_hit_q;
  assign out_value_o = out_val_q;

endmodule

/* src/four_way_label_index_cache.sv */
// ----------------------------------------------------------------------------
// four_way_label_index_cache: four-way set-associative label to index cache
// A non-negative label selects set (label mod NUM_SETS); a lookup returns the
// stored index on a hit, a fill on a miss shifts the set down one way and
// stores the label and fill value in way 0. After reset a clearing pass
// over all NUM_SETS rows sets every tag and value to -1 and no input is taken.
// A negative label goes straight from acceptance to the result hand-off. For
// other labels the set index comes from a mask when NUM_SETS is a power of
// two, or else from a reciprocal multiplication, followed by a row read, a
// compare-and-update step and the result hand-off into the output register.
// A transaction waits in the hand-off state for as long as the output
// register still holds an earlier result that is not taken.
// ----------------------------------------------------------------------------
module four_way_label_index_cache #(
  parameter int unsigned NUM_SETS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] label, [63:32] fill_value
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic        m_axis_tuser    // [0] hit
);

  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  flic_pkg::cmd_t             cmd;
  flic_pkg::status_t          status;
  logic                       ram_wr_en;
  logic [SetW-1:0]            ram_waddr;
  logic [flic_pkg::RowW-1:0]  ram_wdata;
  logic                       ram_rd_en;
  logic [SetW-1:0]            ram_raddr;
  logic [flic_pkg::RowW-1:0]  ram_rdata;

  // Sequencer
  flic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  flic_dp #(
    .NUM_SETS (NUM_SETS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mode_i   (s_axis_tuser),
    .in_label_i  (s_axis_tdata[31:0]),
    .in_fill_i   (s_axis_tdata[63:32]),
    .cmd_i       (cmd),
    .status_o    (status),
    .ram_wr_en_o (ram_wr_en),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_rd_en_o (ram_rd_en),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_hit_o   (m_axis_tuser),
    .out_value_o (m_axis_tdata)
  );

  // Cache rows: four ways of tag and value per set
  flic_ram #(
    .WIDTH (flic_pkg::RowW),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .wr_en_i (ram_wr_en),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .rd_en_i (ram_rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* test/four_way_label_index_cache_tb.sv */
// ----------------------------------------------------------------------------
// four_way_label_index_cache_tb: self-checking bench of the label index cache
// Streams lookup and fill transactions into the cache with random gaps on both
// sides. A behavioral copy of the four-way sets predicts every reply, and each
// reply is compared field by field in arrival order. Directed cases cover
// reset tags, negative labels, eviction and fill on a hit. Random traffic then
// mostly stays on a few crowded sets so that hits, misses and evictions are frequent.
// ----------------------------------------------------------------------------
module four_way_label_index_cache_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSets    = 256;
  localparam int unsigned NumEntries = flic_pkg::NumWays * NumSets;
  localparam int unsigned RandItems  = 1050;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned HoldOff    = 400;
  localparam int unsigned HoldAt     = 200;

  // One reply of the cache
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } cache_reply_t;

  // Behavioral copy of the cache contents and the replies still due
  class label_index_tracker;
    logic [31:0]  way_tag [NumEntries];
    logic [31:0]  way_val [NumEntries];
    cache_reply_t due_replies[$];
    int           errors;
    int           accepted_count;

    function new();
      for (int i = 0; i < NumEntries; i++) begin
        way_tag[i] = '1;
        way_val[i] = '1;
      end
      errors         = 0;
      accepted_count = 0;
    endfunction

    // Update the copy of the sets and queue the reply this transaction causes
    function void note_input(logic mode, logic [31:0] label, logic [31:0] fill);
      cache_reply_t reply;
      int unsigned  base;
      bit           found;
      accepted_count++;
      found = 1'b0;
      reply = '0;
      if (label[31]) begin
        // Pass a negative label straight through
        reply.hit   = 1'b1;
        reply.value = label;
      end else begin
        base = flic_pkg::NumWays * (label % NumSets);
        for (int w = 0; w < flic_pkg::NumWays; w++) begin
          if (!found && way_tag[base + w] == label) begin
            found       = 1'b1;
            reply.hit   = 1'b1;
            reply.value = way_val[base + w];
          end
        end
        if (!found && mode == flic_pkg::ModeFill) begin
          // Shift the set down one way and place the new entry in way 0
          for (int w = flic_pkg::NumWays - 1; w > 0; w--) begin
            way_tag[base + w] = way_tag[base + w - 1];
            way_val[base + w] = way_val[base + w - 1];
          end
          way_tag[base] = label;
          way_val[base] = fill;
          reply.hit     = 1'b1;
          reply.value   = fill;
        end
      end
      due_replies.push_back(reply);
    endfunction

    // Compare an accepted reply with the oldest one due
    function void check_result(logic hit, logic [31:0] value);
      cache_reply_t want;
      if (due_replies.size() == 0) begin
        $error("unexpected reply: hit %0d value %0h", hit, value);
        errors++;
      end else begin
        want = due_replies.pop_front();
        if (hit !== want.hit) begin
          $error("hit mismatch: expected %0d actual %0d", want.hit, hit);
          errors++;
        end
        if (value !== want.value) begin
          $error("value mismatch: expected %0h actual %0h", want.value, value);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return due_replies.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // [31:0] label, [63:32] fill_value
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] value
  logic        m_axis_tuser;         // [0] hit

  label_index_tracker tracker = new();
  bit                 burst_phase = 1'b0;

  four_way_label_index_cache #(
    .NUM_SETS(NumSets)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Watch both handshakes; values read here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tuser, m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      end
    end
  end

  // Hold off the reply side: short stalls mostly, one long hold mid-run
  initial begin
    int unsigned r;
    bit          held;
    held = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!held && tracker.accepted_count >= HoldAt) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end else if (r < 93) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 50)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_phase || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly ordinary indexes, now and then one of the two error codes
  function automatic logic [31:0] pick_fill();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'hFFFF_FFFF;
    if (r < 10) return 32'hFFFF_FFFE;
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  // Crowd labels onto a few sets so that ways fill up and get evicted
  function automatic logic [31:0] pick_label();
    return $urandom_range(0, 5) + NumSets * $urandom_range(0, 6);
  endfunction

  // Offer one transaction and hold it until it is accepted
  task automatic send_item(input logic mode, input logic [31:0] label,
                           input logic [31:0] fill);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fill, label};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int unsigned   sent;
    int unsigned   r;
    logic [31:0]   lbl;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset tags never match
    send_item(flic_pkg::ModeLookup, 32'd0, 32'd0);
    send_item(flic_pkg::ModeLookup, 32'd5, 32'd0);
    // Negative labels pass through in both modes
    send_item(flic_pkg::ModeLookup, 32'h8000_0000, 32'd0);
    send_item(flic_pkg::ModeFill, 32'hFFFF_FFFF, 32'd123);
    send_item(flic_pkg::ModeLookup, 32'hFFFF_FFFF, 32'd0);
    send_item(flic_pkg::ModeFill, 32'h8000_0000, 32'h7FFF_FFFF);
    // Fill set 0 past its four ways, then look back at labels 0, NumSets and 4 * NumSets
    send_item(flic_pkg::ModeFill, 32'd0, 32'h7FFF_FFFF);
    send_item(flic_pkg::ModeLookup, 32'd0, 32'd0);
    send_item(flic_pkg::ModeFill, NumSets, 32'hFFFF_FFFF);
    send_item(flic_pkg::ModeFill, 2 * NumSets, 32'hFFFF_FFFE);
    send_item(flic_pkg::ModeFill, 3 * NumSets, 32'd0);
    send_item(flic_pkg::ModeLookup, 32'd0, 32'd0);
    send_item(flic_pkg::ModeFill, 4 * NumSets, 32'd7);
    send_item(flic_pkg::ModeLookup, 32'd0, 32'd0);
    send_item(flic_pkg::ModeLookup, NumSets, 32'd0);
    send_item(flic_pkg::ModeLookup, 4 * NumSets, 32'd0);
    // Fill on a hit keeps the stored value
    send_item(flic_pkg::ModeFill, NumSets, 32'd99);
    send_item(flic_pkg::ModeLookup, NumSets, 32'd0);
    // Largest label, last set
    send_item(flic_pkg::ModeLookup, 32'h7FFF_FFFF, 32'd0);
    send_item(flic_pkg::ModeFill, 32'h7FFF_FFFF, 32'h5555_5555);
    send_item(flic_pkg::ModeLookup, 32'h7FFF_FFFF, 32'd0);
    send_item(flic_pkg::ModeFill, 32'h7FFF_FFFF - NumSets, 32'h2AAA_AAAA);
    send_item(flic_pkg::ModeLookup, 32'h7FFF_FFFF, 32'd0);

    // Random traffic, mostly lookup then fill of the same label
    sent = 0;
    while (sent < RandItems) begin
      if (sent % 100 == 0) burst_phase = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        lbl = pick_label();
        send_item(flic_pkg::ModeLookup, lbl, pick_fill());
        send_item(flic_pkg::ModeFill, lbl, pick_fill());
        sent += 2;
      end else if (r < 75) begin
        send_item(flic_pkg::ModeLookup, pick_label(), pick_fill());
        sent++;
      end else if (r < 83) begin
        send_item(flic_pkg::ModeFill, pick_label(), pick_fill());
        sent++;
      end else if (r < 90) begin
        send_item(1'($urandom_range(0, 1)), $urandom() | 32'h8000_0000, pick_fill());
        sent++;
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom() & 32'h7FFF_FFFF, pick_fill());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the replies, then watch for strays
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
